[rtl/fsmap_pkg.sv]
// ----------------------------------------------------------------------------
// fsmap_pkg
// Shared types and constants of the flash sector map: table depth, status
// codes, the lookup item that walks the cell chain and the entry write bus.
// ----------------------------------------------------------------------------
package fsmap_pkg;

    // Default number of sector entries (one cell each)
    localparam int TABLE_DEPTH = 128;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int ADDR_W   = 32;
    localparam int BYTES_W  = 25;
    localparam int OFFS_W   = 33;
    localparam int BLOCKS_W = 17;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;
    localparam int INDEX_W  = 7;

    // Configuration port
    localparam int PADDR_W  = 1;
    localparam int PDATA_W  = 32;
    localparam logic [PADDR_W-1:0] REG_PAIRED = 1'b0;

    // Item actions
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // Block size when the CFI unit is zero
    localparam logic [BYTES_W-1:0] ZERO_UNIT_BYTES = 25'h80;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_APPEND  = 4'b0010,
        S_LOOKUP  = 4'b0100,
        S_DELIVER = 4'b1000
    } t_state;

    // Lookup item handed from cell to cell (index travels beside it)
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  start;
        logic [BYTES_W-1:0] bytes;
    } t_tok;

    // Entry write bus from the sequencer to the cells
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  offset;
        logic [BYTES_W-1:0] bytes;
    } t_wr;

    // Byte size of one block from a CFI erase region word
    function automatic logic [BYTES_W-1:0] block_bytes(input logic [WORD_W-1:0] word,
                                                       input logic paired);
        logic [BLOCKS_W-1:0] unit;
        unit = paired ? {word[31:16], 1'b0} : {1'b0, word[31:16]};
        if (unit == '0) begin
            return ZERO_UNIT_BYTES;
        end
        return {unit, 8'h00};
    endfunction

endpackage

[rtl/fsmap_in_if.sv]
// ----------------------------------------------------------------------------
// fsmap_in_if
// Input item channel: append a region word or look up an address.
// ----------------------------------------------------------------------------
interface fsmap_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic                                first_region;
    logic [fsmap_pkg::WORD_W-1:0]        region_info;
    logic [fsmap_pkg::ADDR_W-1:0]        address;

    modport source (output valid, action, first_region, region_info, address,
                    input ready);
    modport sink   (input valid, action, first_region, region_info, address,
                    output ready);
endinterface

[rtl/fsmap_out_if.sv]
// ----------------------------------------------------------------------------
// fsmap_out_if
// Result item channel: status, entry count and the matching sector.
// ----------------------------------------------------------------------------
interface fsmap_out_if;
    logic                                valid;
    logic                                ready;
    logic [fsmap_pkg::STATUS_W-1:0]      status;
    logic [fsmap_pkg::COUNT_W-1:0]       sector_count;
    logic [fsmap_pkg::INDEX_W-1:0]       sector_index;
    logic [fsmap_pkg::ADDR_W-1:0]        sector_start;
    logic [fsmap_pkg::BYTES_W-1:0]       sector_bytes;

    modport source (output valid, status, sector_count, sector_index, sector_start,
                    sector_bytes, input ready);
    modport sink   (input valid, status, sector_count, sector_index, sector_start,
                    sector_bytes, output ready);
endinterface

[rtl/fsmap_cell.sv]
// ----------------------------------------------------------------------------
// fsmap_cell
// One sector entry of the chain. Holds offset and size, takes writes aimed at
// its own index, and passes the lookup item on to its neighbor every cycle,
// marking it with this entry when it is the first one that contains the address.
// ----------------------------------------------------------------------------
module fsmap_cell #(
    parameter  int TABLE_DEPTH = fsmap_pkg::TABLE_DEPTH,
    parameter  int CELL_IDX    = 0,
    localparam int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fsmap_pkg::t_wr       i_wr,
    input  logic [IW-1:0]        i_wr_idx,
    input  logic [CW-1:0]        i_count,
    input  fsmap_pkg::t_tok      i_tok,
    input  logic [IW-1:0]        i_tok_idx,
    output fsmap_pkg::t_tok      o_tok,
    output logic [IW-1:0]        o_tok_idx
);

    logic [fsmap_pkg::ADDR_W-1:0]  r_offset;
    logic [fsmap_pkg::BYTES_W-1:0] r_bytes;
    fsmap_pkg::t_tok               r_tok;
    fsmap_pkg::t_tok               n_tok;
    logic [IW-1:0]                 r_tok_idx;
    logic [IW-1:0]                 n_tok_idx;

    logic [fsmap_pkg::OFFS_W-1:0]  end_addr;
    logic                          held;
    logic                          hit;

    // Entry storage, written by index
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == IW'(CELL_IDX))) begin
            r_offset <= i_wr.offset;
            r_bytes  <= i_wr.bytes;
        end
    end

    // Range test against [offset, offset + bytes), end kept at 33 bits
    assign end_addr = {1'b0, r_offset} + fsmap_pkg::OFFS_W'(r_bytes);
    assign held     = (CW'(CELL_IDX) < i_count);
    assign hit      = held && (i_tok.addr >= r_offset) && ({1'b0, i_tok.addr} < end_addr);

    // Pass the lookup item on, claiming it on the first hit
    always_comb begin
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        if (i_tok.valid && !i_tok.found && hit) begin
            n_tok.found = 1'b1;
            n_tok.start = r_offset;
            n_tok.bytes = r_bytes;
            n_tok_idx   = IW'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found <= n_tok.found;
        r_tok.addr  <= n_tok.addr;
        r_tok.start <= n_tok.start;
        r_tok.bytes <= n_tok.bytes;
        r_tok_idx   <= n_tok_idx;
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

[rtl/fsmap_ctrl.sv]
// ----------------------------------------------------------------------------
// fsmap_ctrl
// Item sequencer: expands region words into one entry write per cycle,
// launches lookup items into the cell chain, and holds the result register.
// ----------------------------------------------------------------------------
module fsmap_ctrl #(
    parameter  int TABLE_DEPTH = fsmap_pkg::TABLE_DEPTH,
    localparam int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fsmap_in_if.sink             i_in,
    fsmap_out_if.source          o_out,
    input  logic                 i_paired,
    output fsmap_pkg::t_wr       o_wr,
    output logic [IW-1:0]        o_wr_idx,
    output logic [CW-1:0]        o_count,
    output fsmap_pkg::t_tok      o_inj,
    input  fsmap_pkg::t_tok      i_tok_end,
    input  logic [IW-1:0]        i_tok_idx_end
);

    fsmap_pkg::t_state                r_state, n_state;
    logic [CW-1:0]                    r_count, n_count;
    logic [fsmap_pkg::OFFS_W-1:0]     r_offset, n_offset;
    logic [fsmap_pkg::BLOCKS_W-1:0]   r_blocks, n_blocks;
    logic [fsmap_pkg::BYTES_W-1:0]    r_bytes, n_bytes;
    logic                             r_inj_valid, n_inj_valid;
    logic [fsmap_pkg::ADDR_W-1:0]     r_inj_addr, n_inj_addr;

    // Finished result waiting for the output register
    logic [fsmap_pkg::STATUS_W-1:0]   r_res_status, n_res_status;
    logic [IW-1:0]                    r_res_idx, n_res_idx;
    logic [fsmap_pkg::ADDR_W-1:0]     r_res_start, n_res_start;
    logic [fsmap_pkg::BYTES_W-1:0]    r_res_bytes, n_res_bytes;

    // Output register
    logic                             r_out_valid, n_out_valid;
    logic [fsmap_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic [fsmap_pkg::COUNT_W-1:0]    r_out_count, n_out_count;
    logic [fsmap_pkg::INDEX_W-1:0]    r_out_idx, n_out_idx;
    logic [fsmap_pkg::ADDR_W-1:0]     r_out_start, n_out_start;
    logic [fsmap_pkg::BYTES_W-1:0]    r_out_bytes, n_out_bytes;

    logic                             accept;
    logic                             full;
    logic                             wr_go;
    logic [31:0]                      count_wide;
    logic [31:0]                      idx_wide;

    assign accept = i_in.valid && i_in.ready;
    assign full   = (r_count >= CW'(TABLE_DEPTH));
    assign wr_go  = (r_state == fsmap_pkg::S_APPEND) && (r_blocks != '0) && !full &&
                    !r_offset[fsmap_pkg::OFFS_W-1];

    // Masked copies for the narrow result fields
    assign count_wide = 32'(r_count);
    assign idx_wide   = 32'(r_res_idx);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_offset     = r_offset;
        n_blocks     = r_blocks;
        n_bytes      = r_bytes;
        n_inj_valid  = 1'b0;
        n_inj_addr   = r_inj_addr;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_start  = r_res_start;
        n_res_bytes  = r_res_bytes;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_idx    = r_out_idx;
        n_out_start  = r_out_start;
        n_out_bytes  = r_out_bytes;

        unique case (r_state)
            fsmap_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_in.action == fsmap_pkg::ACT_APPEND) begin
                        if (i_in.first_region) begin
                            n_count  = '0;
                            n_offset = '0;
                        end
                        n_blocks = {1'b0, i_in.region_info[15:0]} + 17'd1;
                        n_bytes  = fsmap_pkg::block_bytes(i_in.region_info, i_paired);
                        n_state  = fsmap_pkg::S_APPEND;
                    end else begin
                        n_inj_valid = 1'b1;
                        n_inj_addr  = i_in.address;
                        n_state     = fsmap_pkg::S_LOOKUP;
                    end
                end
            end
            fsmap_pkg::S_APPEND: begin
                // One block per cycle until done, full or past 32 bits
                n_res_idx   = '0;
                n_res_start = '0;
                n_res_bytes = '0;
                if (r_blocks == '0) begin
                    n_res_status = fsmap_pkg::STATUS_OK;
                    n_state      = fsmap_pkg::S_DELIVER;
                end else if (full) begin
                    n_res_status = fsmap_pkg::STATUS_FULL;
                    n_state      = fsmap_pkg::S_DELIVER;
                end else if (r_offset[fsmap_pkg::OFFS_W-1]) begin
                    n_res_status = fsmap_pkg::STATUS_OVERFLOW;
                    n_state      = fsmap_pkg::S_DELIVER;
                end else begin
                    n_count  = r_count + CW'(1);
                    n_offset = r_offset + fsmap_pkg::OFFS_W'(r_bytes);
                    n_blocks = r_blocks - 17'd1;
                end
            end
            fsmap_pkg::S_LOOKUP: begin
                // Wait for the lookup item to leave the last cell
                if (i_tok_end.valid) begin
                    if (i_tok_end.found) begin
                        n_res_status = fsmap_pkg::STATUS_OK;
                        n_res_idx    = i_tok_idx_end;
                        n_res_start  = i_tok_end.start;
                        n_res_bytes  = i_tok_end.bytes;
                    end else begin
                        n_res_status = fsmap_pkg::STATUS_NOT_FOUND;
                        n_res_idx    = '0;
                        n_res_start  = '0;
                        n_res_bytes  = '0;
                    end
                    n_state = fsmap_pkg::S_DELIVER;
                end
            end
            fsmap_pkg::S_DELIVER: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_count  = count_wide[fsmap_pkg::COUNT_W-1:0];
                    n_out_idx    = idx_wide[fsmap_pkg::INDEX_W-1:0];
                    n_out_start  = r_res_start;
                    n_out_bytes  = r_res_bytes;
                    n_state      = fsmap_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fsmap_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsmap_pkg::S_IDLE;
            r_count     <= '0;
            r_offset    <= '0;
            r_inj_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_offset    <= n_offset;
            r_inj_valid <= n_inj_valid;
            r_out_valid <= n_out_valid;
        end
        r_blocks     <= n_blocks;
        r_bytes      <= n_bytes;
        r_inj_addr   <= n_inj_addr;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_start  <= n_res_start;
        r_res_bytes  <= n_res_bytes;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_idx    <= n_out_idx;
        r_out_start  <= n_out_start;
        r_out_bytes  <= n_out_bytes;
    end

    // Entry write toward the cell at the current count
    assign o_wr.en     = wr_go;
    assign o_wr.offset = r_offset[fsmap_pkg::ADDR_W-1:0];
    assign o_wr.bytes  = r_bytes;
    assign o_wr_idx    = r_count[IW-1:0];
    assign o_count     = r_count;

    // Lookup item launched into the first cell
    assign o_inj.valid = r_inj_valid;
    assign o_inj.found = 1'b0;
    assign o_inj.addr  = r_inj_addr;
    assign o_inj.start = '0;
    assign o_inj.bytes = '0;

    // Channels
    assign i_in.ready         = (r_state == fsmap_pkg::S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.sector_count = r_out_count;
    assign o_out.sector_index = r_out_idx;
    assign o_out.sector_start = r_out_start;
    assign o_out.sector_bytes = r_out_bytes;

endmodule

[rtl/flash_sector_map.sv]
// ----------------------------------------------------------------------------
// flash_sector_map
// Sector table built from CFI erase region words, with address lookup.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+---------------------------------------
//   i_in     | in  | valid / ready     | action, first_region, region_info,
//            |     |                   | address
//   o_out    | out | valid / ready     | status, sector_count, sector_index,
//            |     |                   | sector_start, sector_bytes
//   APB      | in  | psel/penable, rdy | paired register at address 0
//
// One item at a time. An append writes one entry per cycle until its blocks
// are done, the table is full or the offset has passed 32 bits; its result is
// staged in the sequencer and then moved to the output register. A lookup
// walks the whole cell chain, one cell per cycle; its result is staged once
// the item leaves the last cell. Input ready returns with the result. Reset
// is synchronous and empties the table at once (entry count zero); no
// clearing pass. A stalled result sits in the output register while the next
// item is accepted; that item's result waits in the sequencer until the
// output register is free.
// ----------------------------------------------------------------------------
module flash_sector_map #(
    parameter int TABLE_DEPTH = fsmap_pkg::TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fsmap_in_if.sink                          i_in,
    fsmap_out_if.source                       o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fsmap_pkg::PADDR_W-1:0]     paddr,
    input  logic [fsmap_pkg::PDATA_W-1:0]     pwdata,
    output logic [fsmap_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic            r_paired;
    logic            n_paired;
    fsmap_pkg::t_wr  wr;
    logic [IW-1:0]   wr_idx;
    logic [CW-1:0]   count;
    fsmap_pkg::t_tok tok     [0:TABLE_DEPTH];
    logic [IW-1:0]   tok_idx [0:TABLE_DEPTH];

    // Configuration register
    always_comb begin
        n_paired = r_paired;
        if (psel && penable && pwrite && pready) begin
            case (paddr)
                fsmap_pkg::REG_PAIRED: n_paired = pwdata[0];
                default:               n_paired = r_paired;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paired <= 1'b0;
        end else begin
            r_paired <= n_paired;
        end
    end

    always_comb begin
        case (paddr)
            fsmap_pkg::REG_PAIRED: prdata = {{(fsmap_pkg::PDATA_W-1){1'b0}}, r_paired};
            default:               prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Sequencer
    fsmap_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_paired      (r_paired),
        .o_wr          (wr),
        .o_wr_idx      (wr_idx),
        .o_count       (count),
        .o_inj         (tok[0]),
        .i_tok_end     (tok[TABLE_DEPTH]),
        .i_tok_idx_end (tok_idx[TABLE_DEPTH])
    );

    assign tok_idx[0] = '0;

    // Chain of entry cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        fsmap_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr      (wr),
            .i_wr_idx  (wr_idx),
            .i_count   (count),
            .i_tok     (tok[g]),
            .i_tok_idx (tok_idx[g]),
            .o_tok     (tok[g+1]),
            .o_tok_idx (tok_idx[g+1])
        );
    end

endmodule
